@@ sv/lsfa_pkg.sv @@
// ----------------------------------------------------------------------------
// LED strip frame assembler package
// Shared types and constants: parse modes, result kinds, datapath commands,
// controller status and the command magic.
// ----------------------------------------------------------------------------
`default_nettype none

package lsfa_pkg;

	localparam int MAGIC_BYTES = 16;
	localparam int PIX_LIMIT   = 21834;

	localparam logic [7:0] CMD_MAGIC [MAGIC_BYTES] = '{
		8'h40, 8'h09, 8'h2d, 8'ha6, 8'h15, 8'ha5, 8'hdd, 8'he5,
		8'h6a, 8'h9d, 8'h4d, 8'h5a, 8'hcf, 8'h09, 8'haf, 8'h50
	};

	// configuration register indexes
	localparam logic [0:0] REG_NUM_STRIPS = 1'b0;
	localparam logic [0:0] REG_PIXELS     = 1'b1;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_SEQ,
		MODE_MAGIC,
		MODE_CMD,
		MODE_STRIPS
	} mode_t;

	typedef enum logic [2:0] {
		KIND_PIXEL,
		KIND_FRAME_START,
		KIND_FRAME_END,
		KIND_CMD_CODE,
		KIND_CMD_ARG,
		KIND_DROPPED,
		KIND_GAP_REPORT
	} kind_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LATCH,
		OP_REPORT,
		OP_LEN,
		OP_CHECK,
		OP_BYTE,
		OP_STRIP,
		OP_FSTART,
		OP_POST,
		OP_GAP,
		OP_FINISH
	} op_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  strip;
		logic [15:0] index;
		logic [7:0]  value;
		logic [31:0] gap;
	} result_t;

	typedef struct packed {
		logic  go;
		logic  pend_valid;
		logic  act;
		logic  first;
		mode_t mode;
		logic  len_short;
		logic  rem_busy;
		logic  rem_zero;
		logic  magic_miss;
		logic  strip_dbl;
		logic  flush_more;
		logic  post_end;
	} dp_status_t;

endpackage

`default_nettype wire

@@ sv/led_strip_packet_frame_assembler.sv @@
// ----------------------------------------------------------------------------
// LED strip packet frame assembler
// Splits UDP payload bytes into sequence, command and strip pixel results.
// ----------------------------------------------------------------------------
// Each slave transfer is one payload byte (or a gap report request) and is
// worked on alone: an ordinary byte passes through accept, decode, byte
// step, position update and result drain, with a sequence gap sum step
// added on the last byte of a strip packet or of a packet holding only the
// sequence number. A gap report request, a byte outside any packet and a
// first byte with a length below four pass through accept, decode and
// result drain only. The first byte of an accepted-length packet also runs
// the length check through a serial remainder unit, one quotient bit a
// cycle. When a byte breaks the command magic, the held bytes are replayed
// as strip data one after another, with a frame start step where a repeated
// strip closes the frame. Results leave through a pending register and an
// output register, so the last result of a transfer can be flagged and a
// waiting result does not block the next transfer from being accepted; a
// step that must move a result on while the output register is still full
// holds until the master side takes it.
`default_nettype none

module led_strip_packet_frame_assembler import lsfa_pkg::*; #(
	parameter int MAX_STRIPS = 255
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// slave side
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,  // data_byte[7:0], packet_length[23:8]
	input  wire logic [1:0]  s_tuser,  // action[0], first_byte[1]
	input  wire logic        s_tlast,  // last_byte
	// master side
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata,  // strip_number[7:0], byte_index[23:8],
	                                    // value[31:24], gap_total[63:32]
	output logic [2:0]       m_tuser,  // kind
	output logic             m_tlast,  // last
	// configuration
	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [14:0] cfg_data
);

	op_t        op;
	dp_status_t status;
	result_t    out_res;

	lsfa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.op       (op)
	);

	lsfa_dp #(
		.MAX_STRIPS (MAX_STRIPS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.op               (op),
		.status           (status),
		.in_action        (s_tuser[0]),
		.in_data_byte     (s_tdata[7:0]),
		.in_first_byte    (s_tuser[1]),
		.in_last_byte     (s_tlast),
		.in_packet_length (s_tdata[23:8]),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.out_ready        (m_tready),
		.out_valid        (m_tvalid),
		.out_res          (out_res),
		.out_last         (m_tlast)
	);

	// pack the result fields, strip number in the lowest bits
	assign m_tdata = {out_res.gap, out_res.value, out_res.index, out_res.strip};
	assign m_tuser = out_res.kind;

endmodule

`default_nettype wire

@@ sv/lsfa_rem.sv @@
// ----------------------------------------------------------------------------
// Serial remainder unit
// Restoring division, one quotient bit per cycle; reports whether the
// remainder is zero.
// ----------------------------------------------------------------------------
`default_nettype none

module lsfa_rem (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [15:0] dividend,
	input  wire logic [15:0] divisor,
	output logic             busy,
	output logic             rem_zero
);

	localparam int W  = 16;
	localparam int CW = $clog2(W);

	logic [W-1:0]  rem_q;
	logic [W-1:0]  quo_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [W:0]    trial;
	logic [W:0]    diff;
	logic          fits;

	assign trial = {rem_q, quo_q[W-1]};
	assign fits  = trial >= {1'b0, divisor};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CW'(W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[W-1:0] : trial[W-1:0];
			quo_q <= {quo_q[W-2:0], 1'b0};
		end
	end

	assign busy     = busy_q;
	assign rem_zero = (rem_q == '0);

endmodule

`default_nettype wire

@@ sv/lsfa_dp.sv @@
// ----------------------------------------------------------------------------
// LED strip frame assembler datapath
// Packet state, strip bitmap, held magic bytes, sequence and gap arithmetic,
// and the pending and output result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module lsfa_dp import lsfa_pkg::*; #(
	parameter int MAX_STRIPS = 255
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire op_t         op,
	output dp_status_t       status,
	input  wire logic        in_action,
	input  wire logic [7:0]  in_data_byte,
	input  wire logic        in_first_byte,
	input  wire logic        in_last_byte,
	input  wire logic [15:0] in_packet_length,
	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [14:0] cfg_data,
	input  wire logic        out_ready,
	output logic             out_valid,
	output result_t          out_res,
	output logic             out_last
);

	localparam int         SEEN_W       = (MAX_STRIPS > 1) ? $clog2(MAX_STRIPS) : 1;
	localparam logic [7:0] MAX_STRIPS_C = 8'(MAX_STRIPS);

	// latched input
	logic        act_q, first_q, lastb_q;
	logic [7:0]  byte_q;
	logic [15:0] plen_q;

	logic [7:0]  num_strips_q;
	logic [14:0] pixels_q;
	logic [15:0] size_q;

	logic [31:0] prev_q, cur_q, acc_q;
	logic [31:0] d_s1, g_s1;

	logic [MAX_STRIPS-1:0] seen_q;
	logic [8:0]            count_q;
	logic [7:0]            held_q [MAGIC_BYTES];

	logic [15:0] pos_q, len_q, off_q;
	mode_t       mode_q;
	logic [7:0]  flag_strip_q;
	logic        flag_use_q;
	logic        flush_q;
	logic [3:0]  idx_q, flush_k_q;

	logic        pend_valid_q, out_valid_q, out_last_q;
	result_t     pend_q, out_q;

	logic [7:0]  eff;
	logic [14:0] pix_sat;
	logic [7:0]  src;
	logic        in_range, seen_bit, adv, strip_dbl;
	logic [16:0] off_inc, pos_inc;
	logic [15:0] off_next;
	logic        post_end;
	logic [3:0]  k;
	logic        magic_miss;
	logic [15:0] cmd_i;
	logic        len_short, flush_more;
	logic        rem_busy, rem_zero, rem_start;
	logic        emit, need_out, go;
	result_t     res;

	assign eff       = (num_strips_q > MAX_STRIPS_C) ? MAX_STRIPS_C : num_strips_q;
	assign pix_sat   = (pixels_q > 15'(PIX_LIMIT)) ? 15'(PIX_LIMIT) : pixels_q;
	assign src       = flush_q ? held_q[idx_q] : byte_q;
	assign in_range  = src < eff;
	assign seen_bit  = in_range && seen_q[src[SEEN_W-1:0]];
	assign adv       = (d_s1 != '0) && !d_s1[31];
	assign strip_dbl = (off_q == '0) && seen_bit && adv;
	assign off_inc   = {1'b0, off_q} + 17'd1;
	assign off_next  = (off_inc >= {1'b0, size_q}) ? 16'd0 : off_inc[15:0];
	assign pos_inc   = {1'b0, pos_q} + 17'd1;
	assign post_end  = pos_inc >= {1'b0, len_q};
	assign k         = 4'(pos_q - 16'd4);
	assign magic_miss = byte_q != CMD_MAGIC[k];
	assign cmd_i     = pos_q - 16'(4 + MAGIC_BYTES);
	assign len_short = plen_q < 16'd4;
	assign flush_more = flush_q && (idx_q != flush_k_q);

	// result produced by the current command
	always_comb begin
		emit = 1'b0;
		res  = '0;
		case (op)
			OP_REPORT: begin
				emit     = 1'b1;
				res.kind = KIND_GAP_REPORT;
				res.gap  = acc_q;
			end
			OP_LEN: begin
				emit     = len_short;
				res.kind = KIND_DROPPED;
			end
			OP_CHECK: begin
				emit     = !rem_zero;
				res.kind = KIND_DROPPED;
			end
			OP_BYTE: begin
				case (mode_q)
					MODE_SEQ: begin
						emit = (pos_q == 16'd3) && (len_q > 16'd4)
							&& (len_q < 16'(4 + MAGIC_BYTES)) && (count_q == '0);
						res.kind = KIND_FRAME_START;
					end
					MODE_MAGIC: begin
						emit     = magic_miss && (count_q == '0);
						res.kind = KIND_FRAME_START;
					end
					MODE_CMD: begin
						emit      = 1'b1;
						res.kind  = (cmd_i == '0) ? KIND_CMD_CODE : KIND_CMD_ARG;
						res.index = (cmd_i == '0) ? 16'd0 : cmd_i - 16'd1;
						res.value = byte_q;
					end
					default: begin
						emit = 1'b0;
					end
				endcase
			end
			OP_STRIP: begin
				if (off_q == '0) begin
					emit     = strip_dbl;
					res.kind = KIND_FRAME_END;
				end else begin
					emit      = flag_use_q;
					res.kind  = KIND_PIXEL;
					res.strip = flag_strip_q;
					res.index = off_q - 16'd1;
					res.value = src;
				end
			end
			OP_FSTART: begin
				emit     = 1'b1;
				res.kind = KIND_FRAME_START;
			end
			OP_POST: begin
				if (post_end) begin
					emit     = (mode_q == MODE_STRIPS) && (count_q == {1'b0, eff});
					res.kind = KIND_FRAME_END;
				end else begin
					emit     = lastb_q;
					res.kind = KIND_DROPPED;
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// a result moves pending -> output; hold the step while one must move on into a full output that is not taken
	assign need_out  = pend_valid_q && (emit || (op == OP_FINISH));
	assign go        = !(need_out && out_valid_q && !out_ready);
	assign rem_start = go && (op == OP_LEN) && !len_short;

	lsfa_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (plen_q - 16'd4),
		.divisor  (size_q),
		.busy     (rem_busy),
		.rem_zero (rem_zero)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_strips_q <= '0;
			pixels_q     <= '0;
			size_q       <= 16'd1;
			prev_q       <= '1;
			cur_q        <= '0;
			acc_q        <= '0;
			seen_q       <= '0;
			count_q      <= '0;
			pos_q        <= '0;
			len_q        <= '0;
			off_q        <= '0;
			mode_q       <= MODE_IDLE;
			flag_strip_q <= '0;
			flag_use_q   <= 1'b0;
			flush_q      <= 1'b0;
			idx_q        <= '0;
			flush_k_q    <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
			out_last_q   <= 1'b0;
		end else begin
			size_q <= 16'({2'b00, pix_sat} + {1'b0, pix_sat, 1'b0} + 17'd1);

			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (go && need_out) begin
				out_valid_q <= 1'b1;
				out_last_q  <= (op == OP_FINISH);
			end
			if (go && emit) begin
				pend_valid_q <= 1'b1;
			end else if (go && (op == OP_FINISH)) begin
				pend_valid_q <= 1'b0;
			end

			if (cfg_we) begin
				case (cfg_index)
					REG_NUM_STRIPS: num_strips_q <= cfg_data[7:0];
					REG_PIXELS:     pixels_q     <= cfg_data;
					default:        num_strips_q <= num_strips_q;
				endcase
				seen_q  <= '0;
				count_q <= '0;
				mode_q  <= MODE_IDLE;
			end else if (go) begin
				case (op)
					OP_REPORT: begin
						acc_q <= '0;
					end
					OP_LEN: begin
						len_q <= plen_q;
						off_q <= '0;
						if (len_short) begin
							mode_q <= MODE_IDLE;
						end
					end
					OP_CHECK: begin
						if (!rem_zero) begin
							mode_q <= MODE_IDLE;
						end else begin
							pos_q  <= '0;
							cur_q  <= '0;
							mode_q <= MODE_SEQ;
						end
					end
					OP_BYTE: begin
						case (mode_q)
							MODE_SEQ: begin
								cur_q[{pos_q[1:0], 3'b000} +: 8] <=
									cur_q[{pos_q[1:0], 3'b000} +: 8] | byte_q;
								if (pos_q == 16'd3) begin
									if (len_q >= 16'(4 + MAGIC_BYTES)) begin
										mode_q <= MODE_MAGIC;
									end else if (len_q > 16'd4) begin
										mode_q <= MODE_STRIPS;
										off_q  <= '0;
									end
								end
							end
							MODE_MAGIC: begin
								if (!magic_miss) begin
									if (k == 4'(MAGIC_BYTES - 1)) begin
										mode_q <= MODE_CMD;
									end
								end else begin
									// replay the held bytes as strip data
									mode_q    <= MODE_STRIPS;
									off_q     <= '0;
									flush_q   <= 1'b1;
									idx_q     <= '0;
									flush_k_q <= k;
								end
							end
							default: begin
								mode_q <= mode_q;
							end
						endcase
					end
					OP_STRIP: begin
						if (strip_dbl) begin
							seen_q  <= '0;
							count_q <= '0;
						end else begin
							if (off_q == '0) begin
								flag_strip_q <= src;
								flag_use_q   <= !seen_bit;
								if (in_range && !seen_bit) begin
									seen_q[src[SEEN_W-1:0]] <= 1'b1;
									count_q <= count_q + 9'd1;
								end
							end
							off_q <= off_next;
							if (flush_q) begin
								if (flush_more) idx_q <= idx_q + 4'd1;
								else            flush_q <= 1'b0;
							end
						end
					end
					OP_FSTART: begin
						seen_q[src[SEEN_W-1:0]] <= 1'b1;
						count_q      <= 9'd1;
						flag_strip_q <= src;
						flag_use_q   <= 1'b1;
						off_q        <= off_next;
						if (flush_q) begin
							if (flush_more) idx_q <= idx_q + 4'd1;
							else            flush_q <= 1'b0;
						end
					end
					OP_POST: begin
						pos_q <= pos_inc[15:0];
						if (post_end) begin
							if ((mode_q == MODE_STRIPS) && (count_q == {1'b0, eff})) begin
								seen_q  <= '0;
								count_q <= '0;
							end
							if (mode_q == MODE_CMD) begin
								prev_q <= cur_q;
							end
							mode_q <= MODE_IDLE;
						end else if (lastb_q) begin
							mode_q <= MODE_IDLE;
						end
					end
					OP_GAP: begin
						if ((g_s1 != '0) && !g_s1[31]) begin
							acc_q <= acc_q + g_s1;
						end
						prev_q <= cur_q;
					end
					default: begin
						mode_q <= mode_q;
					end
				endcase
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		d_s1 <= cur_q - prev_q;
		g_s1 <= cur_q - prev_q - 32'd1;
		if (op == OP_LATCH) begin
			act_q   <= in_action;
			first_q <= in_first_byte;
			lastb_q <= in_last_byte;
			byte_q  <= in_data_byte;
			plen_q  <= in_packet_length;
		end
		if (go && (op == OP_BYTE) && (mode_q == MODE_MAGIC)) begin
			held_q[k] <= byte_q;
		end
		if (go && emit) begin
			pend_q <= res;
		end
		if (go && need_out) begin
			out_q <= pend_q;
		end
	end

	always_comb begin
		status            = '0;
		status.go         = go;
		status.pend_valid = pend_valid_q;
		status.act        = act_q;
		status.first      = first_q;
		status.mode       = mode_q;
		status.len_short  = len_short;
		status.rem_busy   = rem_busy;
		status.rem_zero   = rem_zero;
		status.magic_miss = magic_miss;
		status.strip_dbl  = strip_dbl;
		status.flush_more = flush_more;
		status.post_end   = post_end;
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_q;
	assign out_last  = out_last_q;

	a_seen_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(seen_q) == int'(count_q))
		else $error("strip count disagrees with bitmap");

	a_flush_mode: assert property (@(posedge clk) disable iff (!arst_n)
		flush_q |-> (mode_q == MODE_STRIPS))
		else $error("held byte replay outside strip mode");

	a_offset_range: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_STRIPS) |-> (off_q < size_q))
		else $error("strip offset beyond record size");

endmodule

`default_nettype wire

@@ sv/lsfa_ctrl.sv @@
// ----------------------------------------------------------------------------
// LED strip frame assembler controller
// Sequences the datapath through the steps of one input transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module lsfa_ctrl import lsfa_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire dp_status_t status,
	output op_t             op
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_DIV,
		ST_BYTE,
		ST_FLUSH,
		ST_FSTART,
		ST_POST,
		ST_GAP,
		ST_FINISH
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		op      = OP_NONE;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					op      = OP_LATCH;
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (status.act) begin
					op      = OP_REPORT;
					state_d = ST_FINISH;
				end else if (status.first) begin
					op      = OP_LEN;
					state_d = status.len_short ? ST_FINISH : ST_DIV;
				end else if (status.mode == MODE_IDLE) begin
					state_d = ST_FINISH;
				end else begin
					state_d = ST_BYTE;
				end
			end
			ST_DIV: begin
				if (!status.rem_busy) begin
					op      = OP_CHECK;
					state_d = status.rem_zero ? ST_BYTE : ST_FINISH;
				end
			end
			ST_BYTE: begin
				if (status.mode == MODE_STRIPS) begin
					op      = OP_STRIP;
					state_d = status.strip_dbl ? ST_FSTART : ST_POST;
				end else begin
					op = OP_BYTE;
					if ((status.mode == MODE_MAGIC) && status.magic_miss) begin
						state_d = ST_FLUSH;
					end else begin
						state_d = ST_POST;
					end
				end
			end
			ST_FLUSH: begin
				op = OP_STRIP;
				if (status.strip_dbl) state_d = ST_FSTART;
				else                  state_d = status.flush_more ? ST_FLUSH : ST_POST;
			end
			ST_FSTART: begin
				op      = OP_FSTART;
				state_d = status.flush_more ? ST_FLUSH : ST_POST;
			end
			ST_POST: begin
				op = OP_POST;
				if (status.post_end && (status.mode != MODE_CMD)) state_d = ST_GAP;
				else                                              state_d = ST_FINISH;
			end
			ST_GAP: begin
				op      = OP_GAP;
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				op      = OP_FINISH;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		// hold while a result cannot move on
		if (!status.go) begin
			state_d = state_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign s_tready = (state_q == ST_IDLE);

	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !status.pend_valid)
		else $error("result left pending at end of transfer");

endmodule

`default_nettype wire

@@ sim/tb_led_strip_packet_frame_assembler.sv @@
// ----------------------------------------------------------------------------
// LED strip packet frame assembler testbench
// Feeds payload bytes, gap report requests and register writes into the
// assembler. A model kept inside this bench works out the pixel, frame,
// command, drop and gap report results for every accepted transfer. Each
// result that leaves the block is checked against the oldest one waiting.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_led_strip_packet_frame_assembler;
	import lsfa_pkg::*;

	localparam int CYCLE_LIMIT  = 600000;
	localparam int SETTLE_TICKS = 80;     // covers length check plus magic replay
	localparam int RANDOM_ITEMS = 120;

	// one result as the master side carries it
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  strip;
		logic [15:0] idx;
		logic [7:0]  value;
		logic [31:0] gap;
		logic        last;
	} asm_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;   // data_byte[7:0], packet_length[23:8]
	logic [1:0]  s_tuser = '0;   // action[0], first_byte[1]
	logic        s_tlast = 1'b0; // last_byte
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;        // strip[7:0], index[23:8], value[31:24], gap[63:32]
	logic [2:0]  m_tuser;        // kind
	logic        m_tlast;        // last
	logic        cfg_we = 1'b0;
	logic [0:0]  cfg_index = '0;
	logic [14:0] cfg_data = '0;

	led_strip_packet_frame_assembler uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Assembler model state
	// ------------------------------------------------------------------
	int unsigned cfg_strips = 0;
	int unsigned cfg_pixels = 0;
	bit [31:0]   prev_seq = 32'hFFFF_FFFF;
	bit [31:0]   cur_seq = '0;
	bit [31:0]   gap_sum = '0;
	bit          seen_map [255];
	int unsigned seen_n = 0;
	bit [7:0]    held [16];
	int unsigned pkt_pos = 0;
	int unsigned pkt_len = 0;
	int unsigned rec_off = 0;
	mode_t       pmode = MODE_IDLE;
	bit [7:0]    rec_strip = '0;
	bit          rec_use = 1'b0;

	asm_result_t step_results[$];
	asm_result_t expected_results[$];

	int unsigned mismatches = 0;
	int unsigned cycles = 0;
	int unsigned burst_left = 0;

	function void add_result(kind_t k, bit [7:0] s, bit [15:0] i, bit [7:0] v, bit [31:0] g);
		asm_result_t r;
		r.kind = k; r.strip = s; r.idx = i; r.value = v; r.gap = g; r.last = 1'b0;
		step_results.push_back(r);
	endfunction

	function int unsigned record_size();
		return 1 + 3 * ((cfg_pixels > PIX_LIMIT) ? PIX_LIMIT : cfg_pixels);
	endfunction

	function void clear_seen();
		foreach (seen_map[i]) seen_map[i] = 1'b0;
		seen_n = 0;
	endfunction

	function bit seq_moved();
		bit [31:0] d;
		d = cur_seq - prev_seq;
		return d != 0 && !d[31];
	endfunction

	function void open_strips();
		pmode = MODE_STRIPS;
		rec_off = 0;
		if (seen_n == 0) add_result(KIND_FRAME_START, 0, 0, 0, 0);
	endfunction

	// one byte of strip record data: strip number first, then pixels
	function void strip_step(bit [7:0] b);
		if (rec_off == 0) begin
			rec_use = 1'b1;
			if (b < cfg_strips) begin
				if (seen_map[b]) begin
					if (seq_moved()) begin
						add_result(KIND_FRAME_END, 0, 0, 0, 0);
						clear_seen();
						add_result(KIND_FRAME_START, 0, 0, 0, 0);
					end else begin
						rec_use = 1'b0;
					end
				end
				if (!seen_map[b]) begin
					seen_map[b] = 1'b1;
					seen_n++;
				end
			end
			rec_strip = b;
		end else if (rec_use) begin
			add_result(KIND_PIXEL, rec_strip, 16'(rec_off - 1), b, 0);
		end
		rec_off++;
		if (rec_off >= record_size()) rec_off = 0;
	endfunction

	function void close_gap();
		bit [31:0] g;
		g = cur_seq - prev_seq - 1;
		if (g != 0 && !g[31]) gap_sum += g;
		prev_seq = cur_seq;
	endfunction

	function void apply_cfg(bit [0:0] idx, bit [14:0] d);
		if (idx == REG_NUM_STRIPS) cfg_strips = d[7:0];
		else cfg_pixels = d;
		clear_seen();
		pmode = MODE_IDLE;
	endfunction

	// work out every result one accepted transfer causes
	function void assemble_byte(bit act, bit [7:0] b, bit first, bit lastb, bit [15:0] len);
		int unsigned k;
		int unsigned pos;
		bit go;
		go = 1'b1;
		step_results.delete();
		if (act) begin
			add_result(KIND_GAP_REPORT, 0, 0, 0, gap_sum);
			gap_sum = '0;
			go = 1'b0;
		end else if (first) begin
			pkt_len = len;
			rec_off = 0;
			if (len < 4 || (len - 4) % record_size() != 0) begin
				pmode = MODE_IDLE;
				add_result(KIND_DROPPED, 0, 0, 0, 0);
				go = 1'b0;
			end else begin
				pkt_pos = 0;
				cur_seq = '0;
				pmode = MODE_SEQ;
			end
		end else if (pmode == MODE_IDLE) begin
			go = 1'b0;
		end
		if (go) begin
			pos = pkt_pos;
			case (pmode)
				MODE_SEQ: begin
					cur_seq |= 32'(b) << (8 * (pos % 4));
					if (pos == 3) begin
						if (pkt_len - 4 >= MAGIC_BYTES) pmode = MODE_MAGIC;
						else if (pkt_len > 4) open_strips();
					end
				end
				MODE_MAGIC: begin
					k = (pos - 4) % MAGIC_BYTES;
					held[k] = b;
					if (b == CMD_MAGIC[k]) begin
						if (k == MAGIC_BYTES - 1) pmode = MODE_CMD;
					end else begin
						// not a command after all: replay the held bytes as strip data
						open_strips();
						for (int i = 0; i <= k; i++) strip_step(held[i]);
					end
				end
				MODE_CMD: begin
					k = pos - 4 - MAGIC_BYTES;
					if (k == 0) add_result(KIND_CMD_CODE, 0, 0, b, 0);
					else add_result(KIND_CMD_ARG, 0, 16'(k - 1), b, 0);
				end
				default: strip_step(b);
			endcase
			pos++;
			pkt_pos = pos % 65536;
			if (pos >= pkt_len) begin
				if (pmode == MODE_STRIPS) begin
					if (seen_n == cfg_strips) begin
						add_result(KIND_FRAME_END, 0, 0, 0, 0);
						clear_seen();
					end
					close_gap();
				end else if (pmode == MODE_CMD) begin
					prev_seq = cur_seq;
				end else begin
					close_gap();
				end
				pmode = MODE_IDLE;
			end else if (lastb) begin
				pmode = MODE_IDLE;
				add_result(KIND_DROPPED, 0, 0, 0, 0);
			end
		end
		if (step_results.size() > 0) step_results[step_results.size() - 1].last = 1'b1;
		foreach (step_results[i]) expected_results.push_back(step_results[i]);
	endfunction

	// ------------------------------------------------------------------
	// Result checking and receiver stalls
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		asm_result_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = {kind_t'(m_tuser), m_tdata[7:0], m_tdata[23:8], m_tdata[31:24],
				m_tdata[63:32], m_tlast};
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result kind=%0d strip=%0d idx=%0d val=%0h gap=%0d last=%0b",
						got.kind, got.strip, got.idx, got.value, got.gap, got.last);
			end else begin
				want = expected_results.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch exp kind=%0d strip=%0d idx=%0d val=%0h gap=%0d last=%0b / got kind=%0d strip=%0d idx=%0d val=%0h gap=%0d last=%0b",
							want.kind, want.strip, want.idx, want.value, want.gap, want.last,
							got.kind, got.strip, got.idx, got.value, got.gap, got.last);
				end
			end
		end
	end

	// stall pattern: switch between a handful of ready densities
	int unsigned ready_mode = 0;
	int unsigned ready_hold = 0;
	always @(negedge clk) begin
		if (ready_hold == 0) begin
			ready_mode = $urandom_range(0, 3);
			ready_hold = $urandom_range(20, 200);
		end else begin
			ready_hold--;
		end
		case (ready_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 1) == 0);
			2: m_tready <= ($urandom_range(0, 4) != 0);
			default: m_tready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	// hard stop on a hung block
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	// Drive one transfer and hold it until it is accepted; the sender runs in
	// bursts with random gaps between them.
	task automatic send_item(bit act, bit [7:0] b, bit first, bit lastb, bit [15:0] len);
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			if ($urandom_range(0, 3) != 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= {len, b};
		s_tuser  <= {first, act};
		s_tlast  <= lastb;
		do @(posedge clk); while (!s_tready);
		assemble_byte(act, b, first, lastb, len);
	endtask

	// send a packet body; cut below the body size truncates it with last_byte
	task automatic send_packet(bit [7:0] body[$], int unsigned len, int unsigned cut);
		for (int i = 0; i < cut; i++)
			send_item(1'b0, body[i], i == 0, i == cut - 1,
				(i == 0) ? 16'(len) : 16'($urandom));
	endtask

	task automatic put_seq(ref bit [7:0] body[$], input bit [31:0] seq);
		for (int i = 0; i < 4; i++) body.push_back(seq[8*i +: 8]);
	endtask

	task automatic send_strips(bit [31:0] seq, bit [7:0] strips[$], int unsigned cut);
		bit [7:0] body[$];
		put_seq(body, seq);
		foreach (strips[i]) begin
			body.push_back(strips[i]);
			repeat (record_size() - 1) body.push_back(8'($urandom));
		end
		send_packet(body, body.size(), (cut == 0) ? body.size() : cut);
	endtask

	task automatic send_command(bit [31:0] seq, int unsigned nargs, int unsigned cut);
		bit [7:0] body[$];
		put_seq(body, seq);
		for (int i = 0; i < MAGIC_BYTES; i++) body.push_back(CMD_MAGIC[i]);
		repeat (nargs) body.push_back(8'($urandom));
		send_packet(body, body.size(), (cut == 0) ? body.size() : cut);
	endtask

	// magic that breaks at byte k; the packet is sized as whole strip records
	task automatic send_broken_magic(bit [31:0] seq, int unsigned k, int unsigned extra);
		bit [7:0] body[$];
		int unsigned len;
		len = 4 + record_size() * ((MAGIC_BYTES + record_size() - 1) / record_size() + extra);
		put_seq(body, seq);
		for (int i = 0; i < k; i++) body.push_back(CMD_MAGIC[i]);
		body.push_back(CMD_MAGIC[k] ^ 8'($urandom_range(1, 255)));
		while (body.size() < len) body.push_back(8'($urandom));
		send_packet(body, len, len);
	endtask

	task automatic send_report();
		send_item(1'b1, 8'($urandom), 1'($urandom), 1'($urandom), 16'($urandom));
	endtask

	// hold off until the block is idle, then write a register
	task automatic write_reg(bit [0:0] idx, bit [14:0] d);
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE_TICKS) @(posedge clk);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		apply_cfg(idx, d);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic test_length_checks();
		write_reg(REG_NUM_STRIPS, 15'd2);
		write_reg(REG_PIXELS, 15'd1);          // record of four bytes
		send_item(1'b0, 8'h00, 1'b1, 1'b0, 16'd1);       // shorter than the sequence
		send_item(1'b0, 8'hFF, 1'b0, 1'b0, 16'd0);       // stray byte, no packet
		send_item(1'b0, 8'h11, 1'b1, 1'b1, 16'd6);       // not whole records
		send_report();
		send_strips(32'd5, '{8'd0}, 3);                  // short packet
		send_strips(32'd6, '{8'd0}, 6);                  // short packet, cut inside the strip record
		send_strips(32'd7, '{8'd0, 8'd1}, 0);
		send_strips(32'd7, '{8'd1}, 0);                  // an extra byte after the end follows
		send_item(1'b0, 8'h5A, 1'b0, 1'b1, 16'hFFFF);
	endtask

	task automatic test_strip_frames();
		write_reg(REG_NUM_STRIPS, 15'd3);
		send_strips(32'd20, '{8'd0, 8'd1}, 0);
		send_strips(32'd20, '{8'd1}, 0);                 // duplicate, pixels skipped
		send_strips(32'd25, '{8'd0, 8'd3}, 0);           // repeat with advance, untracked strip
		send_strips(32'd26, '{8'd1, 8'd2}, 0);           // completes the frame
		send_report();
		send_report();
	endtask

	task automatic test_commands();
		write_reg(REG_PIXELS, 15'd0);          // record is the strip byte alone
		send_command(32'd100, 0, 0);                     // magic with no code
		send_command(32'd101, 4, 0);
		send_command(32'd130, 3, 10);                    // truncated inside the magic
		send_broken_magic(32'd131, 0, 0);
		send_broken_magic(32'd132, 15, 1);
		send_report();
	endtask

	task automatic test_field_extremes();
		write_reg(REG_PIXELS, 15'h7FFF);       // saturates to the largest record
		write_reg(REG_NUM_STRIPS, 15'h7FFF);   // only the low byte counts: 255 strips
		send_item(1'b0, 8'hFF, 1'b1, 1'b0, 16'd65507);
		send_item(1'b0, 8'h00, 1'b0, 1'b1, 16'h0000);
		send_item(1'b0, 8'hA5, 1'b1, 1'b0, 16'hFFFF);
		write_reg(REG_PIXELS, 15'd1);
		send_strips(32'hFFFF_FFFE, '{8'd254, 8'd255}, 0);
		send_strips(32'h8000_0000, '{8'd254}, 0);
		write_reg(REG_NUM_STRIPS, 15'd0);      // no strips tracked
		send_strips(32'h0000_0001, '{8'd0}, 0);
		send_report();
	endtask

	task automatic test_random_traffic();
		bit [7:0]    strips[$];
		bit [31:0]   seq;
		int unsigned sent, mark, choice, n, ss;
		sent = 0;
		seq = $urandom;
		while (sent < RANDOM_ITEMS) begin
			// new setting every so often, mostly small, now and then the largest count
			write_reg(REG_NUM_STRIPS, ($urandom_range(0, 7) == 0) ? 15'd255
				: 15'($urandom_range(0, 4)) | (15'($urandom) & 15'h7F00));
			write_reg(REG_PIXELS, 15'($urandom_range(0, 3)));
			ss = record_size();
			mark = sent + 60;
			while (sent < mark && sent < RANDOM_ITEMS) begin
				choice = $urandom_range(0, 99);
				if ($urandom_range(0, 9) == 0) seq = $urandom;
				else if ($urandom_range(0, 4) != 0) seq += $urandom_range(0, 3);
				if (choice < 55) begin
					strips.delete();
					repeat ($urandom_range(1, 4))
						strips.push_back(8'($urandom_range(0, (cfg_strips < 255) ? cfg_strips : 254)));
					send_strips(seq, strips, 0);
					sent += 4 + strips.size() * ss;
				end else if (choice < 68) begin
					n = (ss - (MAGIC_BYTES + 1) % ss) % ss + ss * $urandom_range(0, 2);
					send_command(seq, 1 + n, 0);
					sent += 21 + n;
				end else if (choice < 78) begin
					send_broken_magic(seq, $urandom_range(0, MAGIC_BYTES - 1), $urandom_range(0, 1));
					sent += 24;
				end else if (choice < 84) begin
					send_report();
					sent++;
				end else if (choice < 90) begin
					send_item(1'b0, 8'($urandom), 1'b1, 1'($urandom), 16'($urandom));
					sent++;
				end else begin
					// broken sequence: truncated strip packet
					strips.delete();
					repeat ($urandom_range(1, 3)) strips.push_back(8'($urandom_range(0, 5)));
					n = $urandom_range(1, 4 + strips.size() * ss);
					send_strips(seq, strips, n);
					sent += n;
				end
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_length_checks();
		test_strip_frames();
		test_commands();
		test_field_extremes();
		test_random_traffic();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE_TICKS) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire
